// ===== hw/rtl/gcr_rw_pkg.sv =====
// shared types and constants for the gcr read/write shifter
`timescale 1ns / 1ps
package gcr_rw_pkg;

  localparam int unsigned HT_W     = 7;
  localparam int unsigned TRK_W    = HT_W - 1;
  localparam int unsigned SHIFT_W  = 10;
  localparam int unsigned TIMER_W  = 10;
  localparam int unsigned CFG_AW   = 4;
  localparam int unsigned CFG_DW   = 32;

  // reset values of the zone period registers
  localparam logic [7:0] PERIOD_A_RST = 8'd19;
  localparam logic [7:0] PERIOD_B_RST = 8'd18;
  localparam logic [7:0] PERIOD_C_RST = 8'd17;
  localparam logic [7:0] PERIOD_D_RST = 8'd16;

  localparam logic [7:0]         MIN_PERIOD = 8'd4;
  localparam logic [TIMER_W-1:0] TIMER_DEC  = 10'd4;
  localparam logic [TIMER_W-1:0] TIMER_RST  = 10'd19;
  localparam logic [7:0]         PERIOD_RST = 8'd19;

  // first track of speed zones b, c and d
  localparam logic [TRK_W-1:0] TRACK_ZONE_B = 6'd17;
  localparam logic [TRK_W-1:0] TRACK_ZONE_C = 6'd24;
  localparam logic [TRK_W-1:0] TRACK_ZONE_D = 6'd30;

  localparam logic [SHIFT_W-1:0] SYNC_PATTERN = 10'h3FF;
  localparam logic [2:0]         LAST_BIT     = 3'd7;

  typedef enum logic [1:0] {
    REG_ZONE_A = 2'd0,
    REG_ZONE_B = 2'd1,
    REG_ZONE_C = 2'd2,
    REG_ZONE_D = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] zone_a;
    logic [7:0] zone_b;
    logic [7:0] zone_c;
    logic [7:0] zone_d;
  } cfg_t;

  typedef struct packed {
    logic [1:0] step_phase;
    logic       motor_on;
    logic       read_mode;
    logic       ready_enable;
    logic [7:0] write_data;
    logic       disk_bit;
  } in_item_t;

  typedef struct packed {
    logic [7:0]      read_data;
    logic            sync_n;
    logic            byte_ready;
    logic            bit_tick;
    logic            write_strobe;
    logic            write_bit;
    logic [HT_W-1:0] half_track;
  } out_item_t;

  typedef struct packed {
    logic [HT_W-1:0] half_track;
    logic            tick_due;
  } step_t;

endpackage

// ===== hw/rtl/gcr_rw_stepper.sv =====
// head stepper, speed zone select and bit timer
`timescale 1ns / 1ps
module gcr_rw_stepper #(
  parameter int unsigned MAX_HALF_TRACK = 70
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  logic [1:0]          step_phase,
  input  gcr_rw_pkg::cfg_t    cfg,
  output gcr_rw_pkg::step_t   step
);

  localparam logic [gcr_rw_pkg::HT_W-1:0] MAX_HT = gcr_rw_pkg::HT_W'(MAX_HALF_TRACK);

  logic [1:0]                         phase_r, phase_nxt;
  logic [gcr_rw_pkg::HT_W-1:0]        track_r, track_nxt;
  logic [7:0]                         period_r, period_nxt;
  logic [gcr_rw_pkg::TIMER_W-1:0]     timer_r, timer_nxt, timer_dec;
  logic [gcr_rw_pkg::TRK_W-1:0]       trk;
  logic                               step_out;
  logic                               due;
  logic [7:0]                         zone_p;

  // step direction and clamped head move
  always_comb begin
    phase_nxt  = step_phase;
    track_nxt  = track_r;
    period_nxt = period_r;
    step_out   = (step_phase == 2'd3 && phase_r == 2'd0) || (step_phase < phase_r);
    if (step_phase == 2'd0 && phase_r == 2'd3) begin
      step_out = 1'b0;
    end
    trk = track_nxt[gcr_rw_pkg::HT_W-1:1];
    zone_p = cfg.zone_d;
    if (step_phase != phase_r) begin
      if (step_out) begin
        track_nxt = (track_r == '0) ? track_r : track_r - 1'b1;
      end else begin
        track_nxt = (track_r >= MAX_HT) ? MAX_HT : track_r + 1'b1;
      end
      // speed zone of the new track
      trk = track_nxt[gcr_rw_pkg::HT_W-1:1];
      if (trk < gcr_rw_pkg::TRACK_ZONE_B) begin
        zone_p = cfg.zone_a;
      end else if (trk < gcr_rw_pkg::TRACK_ZONE_C) begin
        zone_p = cfg.zone_b;
      end else if (trk < gcr_rw_pkg::TRACK_ZONE_D) begin
        zone_p = cfg.zone_c;
      end
      period_nxt = (zone_p < gcr_rw_pkg::MIN_PERIOD) ? gcr_rw_pkg::MIN_PERIOD : zone_p;
    end
  end

  // bit timer: count down, add the zone period at zero or below
  always_comb begin
    timer_dec = timer_r - gcr_rw_pkg::TIMER_DEC;
    due       = timer_dec[gcr_rw_pkg::TIMER_W-1] || (timer_dec == '0);
    timer_nxt = due ? timer_dec + {2'b00, period_nxt} : timer_dec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= '0;
      track_r  <= '0;
      period_r <= gcr_rw_pkg::PERIOD_RST;
      timer_r  <= gcr_rw_pkg::TIMER_RST;
    end else if (advance) begin
      phase_r  <= phase_nxt;
      track_r  <= track_nxt;
      period_r <= period_nxt;
      timer_r  <= timer_nxt;
    end
  end

  assign step.half_track = track_nxt;
  assign step.tick_due   = due;

endmodule

// ===== hw/rtl/gcr_rw_shifter.sv =====
// read/write shift register with sync and byte detect
`timescale 1ns / 1ps
module gcr_rw_shifter (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  advance,
  input  gcr_rw_pkg::in_item_t  item,
  input  gcr_rw_pkg::step_t     step,
  output gcr_rw_pkg::out_item_t result
);

  logic [gcr_rw_pkg::SHIFT_W-1:0] shift_r, shift_nxt, shift_in;
  logic [2:0]                     count_r, count_nxt;
  logic                           byte_flag_r, byte_flag_nxt;
  logic                           sync_flag_n_r, sync_flag_n_nxt;
  logic                           held_sync_n_r, held_sync_n_nxt;
  logic                           held_ready_r, held_ready_nxt;
  logic                           tick, hold, strobe, wbit;
  logic                           sync_out, ready_out;

  always_comb begin
    shift_nxt       = shift_r;
    count_nxt       = count_r;
    byte_flag_nxt   = byte_flag_r;
    sync_flag_n_nxt = sync_flag_n_r;
    shift_in        = shift_r;
    strobe          = 1'b0;
    wbit            = 1'b0;
    tick            = step.tick_due && item.motor_on;
    hold            = step.tick_due && !item.motor_on;
    if (tick) begin
      if (item.read_mode) begin
        // read: shift disk bit in, ten ones is sync
        shift_nxt       = {shift_r[gcr_rw_pkg::SHIFT_W-2:0], item.disk_bit};
        sync_flag_n_nxt = (shift_nxt != gcr_rw_pkg::SYNC_PATTERN);
        if (!sync_flag_n_nxt) begin
          count_nxt     = '0;
          byte_flag_nxt = 1'b0;
        end else begin
          count_nxt     = count_r + 1'b1;
          byte_flag_nxt = (count_r == gcr_rw_pkg::LAST_BIT);
        end
      end else begin
        // write: load byte at byte start, shift out msb first
        if (count_r == '0) begin
          shift_in = {2'b00, item.write_data};
        end
        wbit          = shift_in[7];
        strobe        = 1'b1;
        shift_nxt     = {2'b00, shift_in[6:0], 1'b0};
        count_nxt     = count_r + 1'b1;
        byte_flag_nxt = (count_r == gcr_rw_pkg::LAST_BIT);
      end
    end
    // motor off at a due tick holds the last driven flags
    if (hold) begin
      sync_out  = held_sync_n_r;
      ready_out = held_ready_r;
    end else begin
      sync_out  = sync_flag_n_nxt;
      ready_out = byte_flag_nxt && item.ready_enable;
    end
    held_sync_n_nxt = sync_out;
    held_ready_nxt  = ready_out;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r       <= '0;
      count_r       <= '0;
      byte_flag_r   <= 1'b0;
      sync_flag_n_r <= 1'b0;
      held_sync_n_r <= 1'b1;
      held_ready_r  <= 1'b0;
    end else if (advance) begin
      shift_r       <= shift_nxt;
      count_r       <= count_nxt;
      byte_flag_r   <= byte_flag_nxt;
      sync_flag_n_r <= sync_flag_n_nxt;
      held_sync_n_r <= held_sync_n_nxt;
      held_ready_r  <= held_ready_nxt;
    end
  end

  assign result.read_data    = shift_nxt[7:0];
  assign result.sync_n       = sync_out;
  assign result.byte_ready   = ready_out;
  assign result.bit_tick     = tick;
  assign result.write_strobe = strobe;
  assign result.write_bit    = wbit;
  assign result.half_track   = step.half_track;

endmodule

// ===== hw/rtl/gcr_disk_read_write_shifter_unit.sv =====
// top level: request registers, config registers, stepper and shifter
//
//  channel | ports                                    | role
//  in_     | in_valid, in_ready, in_data              | one clock of drive inputs
//  out_    | out_valid, out_ready, out_data           | one result per request
//  cfg     | psel, penable, pwrite, paddr, pwdata,    | zone period registers
//          | prdata, pready                           |
//
// one request per clock while out_ready is high: an input register, one pass
// of logic and a result register, loaded from the input register on advance
// a stalled result holds both stages; in_ready drops only when both are full
// reset is synchronous and returns the head to half track 0 and the timer to 19
`timescale 1ns / 1ps
module gcr_disk_read_write_shifter_unit #(
  parameter int unsigned MAX_HALF_TRACK = 70
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  gcr_rw_pkg::in_item_t                in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output gcr_rw_pkg::out_item_t               out_data,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [gcr_rw_pkg::CFG_AW-1:0]       paddr,
  input  logic [gcr_rw_pkg::CFG_DW-1:0]       pwdata,
  output logic [gcr_rw_pkg::CFG_DW-1:0]       prdata,
  output logic                                pready
);

  gcr_rw_pkg::cfg_t       cfg_r;
  gcr_rw_pkg::in_item_t   s1_item_r;
  logic                   s1_valid_r;
  gcr_rw_pkg::out_item_t  out_item_r, result;
  logic                   out_valid_r;
  gcr_rw_pkg::step_t      step;
  gcr_rw_pkg::cfg_reg_e   reg_sel;
  logic                   advance;
  logic                   cfg_wr;

  // handshake between the two stages
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  // config port
  assign pready  = 1'b1;
  assign reg_sel = gcr_rw_pkg::cfg_reg_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    case (reg_sel)
      gcr_rw_pkg::REG_ZONE_A: prdata = {24'd0, cfg_r.zone_a};
      gcr_rw_pkg::REG_ZONE_B: prdata = {24'd0, cfg_r.zone_b};
      gcr_rw_pkg::REG_ZONE_C: prdata = {24'd0, cfg_r.zone_c};
      gcr_rw_pkg::REG_ZONE_D: prdata = {24'd0, cfg_r.zone_d};
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.zone_a <= gcr_rw_pkg::PERIOD_A_RST;
      cfg_r.zone_b <= gcr_rw_pkg::PERIOD_B_RST;
      cfg_r.zone_c <= gcr_rw_pkg::PERIOD_C_RST;
      cfg_r.zone_d <= gcr_rw_pkg::PERIOD_D_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        gcr_rw_pkg::REG_ZONE_A: cfg_r.zone_a <= pwdata[7:0];
        gcr_rw_pkg::REG_ZONE_B: cfg_r.zone_b <= pwdata[7:0];
        gcr_rw_pkg::REG_ZONE_C: cfg_r.zone_c <= pwdata[7:0];
        gcr_rw_pkg::REG_ZONE_D: cfg_r.zone_d <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_data;
    end
  end

  gcr_rw_stepper #(
    .MAX_HALF_TRACK (MAX_HALF_TRACK)
  ) u_stepper (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .step_phase (s1_item_r.step_phase),
    .cfg        (cfg_r),
    .step       (step)
  );

  gcr_rw_shifter u_shifter (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (s1_item_r),
    .step    (step),
    .result  (result)
  );

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

// ===== hw/rtl/gcr_rw_checker.sv =====
// port checker for the gcr read/write shifter and its bind
`timescale 1ns / 1ps
module gcr_rw_checker #(
  parameter int unsigned MAX_HALF_TRACK = 70
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input gcr_rw_pkg::out_item_t out_data
);

  // an empty result stage never blocks requests
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("in_ready low with empty result stage");

  // head stays within the clamp range
  a_track_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.half_track <= (gcr_rw_pkg::HT_W)'(MAX_HALF_TRACK)))
    else $error("half_track beyond limit");

  // a write strobe only comes with a bit tick
  a_strobe_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.write_strobe) |-> out_data.bit_tick)
    else $error("write_strobe without bit_tick");

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind gcr_disk_read_write_shifter_unit gcr_rw_checker #(
  .MAX_HALF_TRACK (MAX_HALF_TRACK)
) u_gcr_rw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== sim/gcr_shifter_checker.sv =====
// checker for the gcr shifter: mirrors the drive logic and compares every result
`timescale 1ns / 1ps
module gcr_shifter_checker
  import gcr_rw_pkg::*;
#(
  parameter int MAX_HALF_TRACK = 70
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_AW-1:0]     paddr,
  input  logic [CFG_DW-1:0]     pwdata,
  input  logic                  pready,
  output int                    pending,
  output int                    mismatches
);

  // mirrored drive state
  logic [7:0]         zone_reg [4];
  logic [SHIFT_W-1:0] shreg;
  logic [2:0]         bits_seen;
  logic               byte_done;
  logic               sync_n_flag;
  logic               held_sync;
  logic               held_rdy;
  logic [1:0]         last_phase;
  logic [HT_W-1:0]    head_pos;
  int                 bit_timer;
  logic [7:0]         period_now;

  out_item_t expected_results [$];
  out_item_t want;
  int        results_seen;

  initial begin
    mismatches   = 0;
    results_seen = 0;
    pending      = 0;
  end

  task automatic report_mismatch(string what, int got, int exp_val);
    if (mismatches < 30) begin
      $display("result %0d: %s got %0d, expected %0d", results_seen, what, got, exp_val);
    end
    mismatches++;
  endtask

  // bit period of the speed zone that holds this half track
  function automatic logic [7:0] zone_for(logic [HT_W-1:0] pos);
    logic [TRK_W-1:0] trk;
    logic [7:0]       p;
    trk = pos[HT_W-1:1];
    if (trk < TRACK_ZONE_B) begin
      p = zone_reg[REG_ZONE_A];
    end else if (trk < TRACK_ZONE_C) begin
      p = zone_reg[REG_ZONE_B];
    end else if (trk < TRACK_ZONE_D) begin
      p = zone_reg[REG_ZONE_C];
    end else begin
      p = zone_reg[REG_ZONE_D];
    end
    if (p < MIN_PERIOD) p = MIN_PERIOD;
    return p;
  endfunction

  // one clock of the drive: stepper, bit timer, shifter, output hold
  function automatic out_item_t drive_step(in_item_t req);
    out_item_t  res;
    logic       hold;
    logic [7:0] per;
    logic [3:0] cnt;
    int         next_pos;
    res  = '0;
    hold = 1'b0;

    // stepper: phase change moves the head one half track
    if (req.step_phase != last_phase) begin
      next_pos = int'(head_pos) + 1;
      if (req.step_phase < last_phase || (req.step_phase == 2'd3 && last_phase == 2'd0)) begin
        next_pos = int'(head_pos) - 1;
      end
      if (req.step_phase == 2'd0 && last_phase == 2'd3) next_pos = int'(head_pos) + 1;
      if (next_pos > MAX_HALF_TRACK) next_pos = MAX_HALF_TRACK;
      if (next_pos < 0) next_pos = 0;
      head_pos   = next_pos[HT_W-1:0];
      period_now = zone_for(head_pos);
      last_phase = req.step_phase;
    end

    // bit timer
    bit_timer = bit_timer - int'(TIMER_DEC);
    if (bit_timer <= 0) begin
      per = (period_now < MIN_PERIOD) ? MIN_PERIOD : period_now;
      bit_timer = bit_timer + int'(per);
      if (!req.motor_on) begin
        hold = 1'b1;
      end else begin
        res.bit_tick = 1'b1;
        if (req.read_mode) begin
          shreg       = {shreg[SHIFT_W-2:0], req.disk_bit};
          byte_done   = 1'b0;
          sync_n_flag = 1'b1;
          cnt         = {1'b0, bits_seen} + 4'd1;
          if (shreg == SYNC_PATTERN) begin
            sync_n_flag = 1'b0;
            cnt         = '0;
          end
          if (cnt == 4'd8) begin
            byte_done = 1'b1;
            cnt       = '0;
          end
          bits_seen = cnt[2:0];
        end else begin
          if (bits_seen == 3'd0) shreg = {2'b00, req.write_data};
          res.write_bit    = shreg[7];
          res.write_strobe = 1'b1;
          shreg            = {2'b00, shreg[6:0], 1'b0};
          byte_done        = 1'b0;
          cnt              = {1'b0, bits_seen} + 4'd1;
          if (cnt == 4'd8) begin
            byte_done = 1'b1;
            cnt       = '0;
          end
          bits_seen = cnt[2:0];
        end
      end
    end

    // motor off at a tick keeps the last driven flags
    if (hold) begin
      res.sync_n     = held_sync;
      res.byte_ready = held_rdy;
    end else begin
      res.sync_n     = sync_n_flag;
      res.byte_ready = byte_done & req.ready_enable;
      held_sync      = res.sync_n;
      held_rdy       = res.byte_ready;
    end
    res.read_data  = shreg[7:0];
    res.half_track = head_pos;
    return res;
  endfunction

  // watch the channels
  always @(posedge clk) begin
    if (!rst_n) begin
      zone_reg[REG_ZONE_A] = PERIOD_A_RST;
      zone_reg[REG_ZONE_B] = PERIOD_B_RST;
      zone_reg[REG_ZONE_C] = PERIOD_C_RST;
      zone_reg[REG_ZONE_D] = PERIOD_D_RST;
      shreg       = '0;
      bits_seen   = '0;
      byte_done   = 1'b0;
      sync_n_flag = 1'b0;
      held_sync   = 1'b1;
      held_rdy    = 1'b0;
      last_phase  = '0;
      head_pos    = '0;
      bit_timer   = int'(TIMER_RST);
      period_now  = PERIOD_RST;
      expected_results.delete();
      pending <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with no request pending", 1, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_data.read_data != want.read_data)
            report_mismatch("read_data", out_data.read_data, want.read_data);
          if (out_data.sync_n != want.sync_n)
            report_mismatch("sync_n", out_data.sync_n, want.sync_n);
          if (out_data.byte_ready != want.byte_ready)
            report_mismatch("byte_ready", out_data.byte_ready, want.byte_ready);
          if (out_data.bit_tick != want.bit_tick)
            report_mismatch("bit_tick", out_data.bit_tick, want.bit_tick);
          if (out_data.write_strobe != want.write_strobe)
            report_mismatch("write_strobe", out_data.write_strobe, want.write_strobe);
          if (out_data.write_bit != want.write_bit)
            report_mismatch("write_bit", out_data.write_bit, want.write_bit);
          if (out_data.half_track != want.half_track)
            report_mismatch("half_track", out_data.half_track, want.half_track);
        end
        results_seen++;
      end
      if (psel && penable && pwrite && pready) begin
        zone_reg[cfg_reg_e'(paddr[3:2])] = pwdata[7:0];
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(drive_step(in_data));
      end
      pending <= expected_results.size();
    end
  end

endmodule

// ===== sim/gcr_disk_read_write_shifter_unit_tb.sv =====
// testbench top for the gcr shifter: clock, reset, requests, config writes, verdict
`timescale 1ns / 1ps
module gcr_disk_read_write_shifter_unit_tb;
  import gcr_rw_pkg::*;

  localparam int HALF_TRACK_MAX = 70;
  localparam int QUIET_LIMIT    = 500;
  localparam int LONG_HOLD      = 60;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  in_item_t          in_data;
  logic              out_valid;
  logic              out_ready;
  out_item_t         out_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  int         pending;
  int         mismatches;
  int         quiet_cycles = 0;
  bit         idle_on      = 1'b0;
  bit         long_hold_due = 1'b0;
  logic [1:0] phase_now    = 2'd0;

  always #10 clk = ~clk;

  gcr_disk_read_write_shifter_unit #(
    .MAX_HALF_TRACK(HALF_TRACK_MAX)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  gcr_shifter_checker #(
    .MAX_HALF_TRACK(HALF_TRACK_MAX)
  ) result_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .pready    (pready),
    .pending   (pending),
    .mismatches(mismatches)
  );

  // watchdog on cycles with no handshake of any kind
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // result side: random stalls plus one long hold to back up the pipeline
  initial begin : result_side
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold_due) begin
        long_hold_due = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // one register write: setup then access
  task automatic write_zone(cfg_reg_e idx, logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_zones(logic [7:0] a, logic [7:0] b, logic [7:0] c, logic [7:0] d);
    write_zone(REG_ZONE_A, a);
    write_zone(REG_ZONE_B, b);
    write_zone(REG_ZONE_C, c);
    write_zone(REG_ZONE_D, d);
  endtask

  // offer one request and hold it until accepted
  task automatic send_request(in_item_t req);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop offering and let every pending result come back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // head walks in segments: stepping in, stepping out or noise, with disk content per segment
  task automatic run_phase(int count, bit hold_once, bit allow_idle);
    in_item_t req;
    int       seg_left;
    int       walk;
    int       step_every;
    int       disk_kind;
    bit       motor_seg;
    bit       read_seg;
    seg_left   = 0;
    walk       = 0;
    step_every = 1;
    disk_kind  = 0;
    motor_seg  = 1'b1;
    read_seg   = 1'b1;
    for (int k = 0; k < count; k++) begin
      if (seg_left == 0) begin
        seg_left   = $urandom_range(20, 60);
        walk       = $urandom_range(0, 3);
        step_every = $urandom_range(1, 3);
        disk_kind  = $urandom_range(0, 2);
        read_seg   = ($urandom_range(0, 3) != 0);
        motor_seg  = ($urandom_range(0, 7) != 0);
        idle_on    = allow_idle && ($urandom_range(0, 3) != 0);
      end
      seg_left--;
      if (hold_once && k == count / 2) long_hold_due = 1'b1;

      // stepper phase
      if (k % step_every == 0) begin
        case (walk)
          0, 1:    phase_now = phase_now + 2'd1;
          2:       phase_now = phase_now - 2'd1;
          default: phase_now = 2'($urandom_range(0, 3));
        endcase
      end
      if ($urandom_range(0, 15) == 0) phase_now = 2'($urandom_range(0, 3));
      req.step_phase = phase_now;

      req.motor_on = motor_seg ? ($urandom_range(0, 15) != 0) : ($urandom_range(0, 3) == 0);
      req.read_mode = ($urandom_range(0, 31) == 0) ? !read_seg : read_seg;
      req.ready_enable = ($urandom_range(0, 7) != 0);
      req.write_data = 8'($urandom);
      case (disk_kind)
        0:       req.disk_bit = 1'b1;
        1:       req.disk_bit = 1'($urandom_range(0, 1));
        default: req.disk_bit = ($urandom_range(0, 3) != 0);
      endcase
      send_request(req);
    end
  endtask

  initial begin : stimulus
    in_item_t   req;
    logic [1:0] walk_pattern [8];
    walk_pattern = '{2'd3, 2'd0, 2'd1, 2'd2, 2'd3, 2'd2, 2'd1, 2'd0};

    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: a tick on every request once the timer runs down, both step directions,
    // clamp at zero, ten ones for sync, then write mode with motor off mid stream
    write_zone(REG_ZONE_A, MIN_PERIOD);
    idle_on = 1'b1;
    for (int i = 0; i < 24; i++) begin
      phase_now        = walk_pattern[i % 8];
      req.step_phase   = phase_now;
      req.motor_on     = !(i == 20 || i == 21);
      req.read_mode    = (i < 16);
      req.ready_enable = (i != 15);
      case (i % 3)
        0:       req.write_data = 8'hFF;
        1:       req.write_data = 8'h00;
        default: req.write_data = 8'h5A;
      endcase
      req.disk_bit = (i < 14) ? 1'b1 : 1'(i % 2);
      send_request(req);
    end

    // random phases, each under its own zone settings
    settle();
    write_zones(8'd4, 8'd4, 8'd4, 8'd4);
    run_phase(100, 1'b0, 1'b1);

    settle();
    write_zones(8'($urandom_range(4, 24)), 8'($urandom_range(4, 24)),
                8'($urandom_range(4, 24)), 8'($urandom_range(4, 24)));
    run_phase(100, 1'b0, 1'b1);

    settle();
    write_zones(8'd255, 8'd255, 8'd255, 8'd255);
    run_phase(80, 1'b0, 1'b1);

    // zone values below the minimum period are raised to it
    settle();
    write_zones(8'd0, 8'd1, 8'd2, 8'd3);
    run_phase(100, 1'b0, 1'b1);

    settle();
    write_zones(8'($urandom_range(4, 40)), 8'($urandom_range(4, 40)),
                8'($urandom_range(4, 40)), 8'($urandom_range(4, 40)));
    run_phase(120, 1'b1, 1'b1);

    // last stretch without idling on either side
    settle();
    write_zones(PERIOD_A_RST, PERIOD_B_RST, PERIOD_C_RST, PERIOD_D_RST);
    run_phase(100, 1'b0, 1'b0);

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
